### design/csha_pkg.sv
// Shared types, widths and codes for the channel statistics histogram block.
// No dependencies; every other file of the block but csha_bin_mem imports it.
package csha_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int MAX_BINS_DEF   = 256;
  localparam int COUNT_BITS_DEF = 32;

  localparam int MODE_W    = 2;
  localparam int CH_PORT_W = 2;
  localparam int SAMPLE_W  = 17;
  localparam int HIGH_W    = 18;
  localparam int CLASS_W   = 2;
  localparam int SEL_W     = 8;
  localparam int BINS_W    = 9;
  localparam int OUT_CNT_W = 32;
  localparam int STATUS_W  = 2;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam int DIFF_W = SAMPLE_W;
  localparam int NUM_W  = DIFF_W + BINS_W;
  localparam int SPAN_W = HIGH_W;

  localparam logic [HIGH_W-1:0] HIST_HIGH_RST = HIGH_W'(256);
  localparam logic [BINS_W-1:0] BINS_RST      = BINS_W'(256);

  typedef enum logic [MODE_W-1:0] {
    MODE_OBSERVE = 2'd0,
    MODE_READ    = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_PEEK    = 2'd3
  } mode_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_FINITE  = 2'd0,
    CLS_NAN     = 2'd1,
    CLS_POS_INF = 2'd2,
    CLS_NEG_INF = 2'd3
  } class_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_NONE = 2'd0,
    STAT_BIN  = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_HIST_ENABLE = 2'd0,
    REG_HIST_LOW    = 2'd1,
    REG_HIST_HIGH   = 2'd2,
    REG_BINS_IN_USE = 2'd3
  } reg_idx_t;

endpackage

### design/csha_div.sv
// Restoring divider, one quotient bit per cycle, for the bin index.
// Depends on csha_pkg for operand widths.
module csha_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [csha_pkg::NUM_W-1:0]  numer,
  input  logic [csha_pkg::SPAN_W-1:0] denom,
  output logic                       done,
  output logic [csha_pkg::NUM_W-1:0]  quot
);
  import csha_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] rem_next;
  logic [NUM_W-1:0]  q;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [SPAN_W:0]   trial;
  logic              qbit;

  always_comb begin
    trial    = {rem, q[NUM_W-1]};
    qbit     = trial >= {1'b0, denom};
    rem_next = qbit ? SPAN_W'(trial - {1'b0, denom}) : SPAN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        q   <= numer;
        cnt <= CNT_W'(NUM_W);
        run <= 1'b1;
      end else if (run) begin
        rem <= rem_next;
        q   <= {q[NUM_W-2:0], qbit};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule

### design/csha_bin_mem.sv
// Bin count store: one write port, one read port, registered read data.
// No package dependencies.
module csha_bin_mem #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/channel_stats_histogram_accumulator_core.sv
// Top level of the channel statistics histogram block: config port, control
// sequencer and per-channel counters. Depends on csha_pkg, csha_div, csha_bin_mem.
//
// Usage: write hist_enable, hist_low, hist_high and bins_in_use over the APB
// port (byte addresses 0, 4, 8, 12) while the block is idle. Send items on the
// input channel (in_valid/in_ready); each beat yields exactly one result beat
// on the output channel (out_valid/out_ready), in order.
// A sample that lands in a bin passes through the counter update, the
// one-bit-per-cycle divider, then the bin store read and write-back.
// Other samples pass only the counter update; counter reads and invalid
// channels go straight to the result. Bin reads use the registered store port.
// Clear-all (mode 2) sweeps all CHANNELS * MAX_BINS entries of the bin store,
// one entry per cycle, before its result appears.
// One item is in flight at a time; in_ready is high only while idle.
// Reset: synchronous; counters clear at once, then the same sweep clears the
// bin store while in_ready stays low. Config writes are taken at any time.
// A stalled receiver holds the result in the output register; the block may
// still accept and process the next item, then waits to present it.
module channel_stats_histogram_accumulator_core #(
  parameter int CHANNELS   = csha_pkg::CHANNELS_DEF,
  parameter int MAX_BINS   = csha_pkg::MAX_BINS_DEF,
  parameter int COUNT_BITS = csha_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [csha_pkg::PADDR_W-1:0]    paddr,
  input  logic [csha_pkg::PDATA_W-1:0]    pwdata,
  output logic [csha_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [csha_pkg::MODE_W-1:0]     mode,
  input  logic [csha_pkg::CH_PORT_W-1:0]  channel,
  input  logic signed [csha_pkg::SAMPLE_W-1:0] sample,
  input  logic [csha_pkg::CLASS_W-1:0]    sample_class,
  input  logic [csha_pkg::SEL_W-1:0]      bin_select,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [csha_pkg::OUT_CNT_W-1:0]  finite_total,
  output logic [csha_pkg::OUT_CNT_W-1:0]  nan_total,
  output logic [csha_pkg::OUT_CNT_W-1:0]  pos_inf_total,
  output logic [csha_pkg::OUT_CNT_W-1:0]  neg_inf_total,
  output logic [csha_pkg::OUT_CNT_W-1:0]  below_total,
  output logic [csha_pkg::OUT_CNT_W-1:0]  above_total,
  output logic signed [csha_pkg::SAMPLE_W-1:0] min_seen,
  output logic signed [csha_pkg::SAMPLE_W-1:0] max_seen,
  output logic                            has_finite,
  output logic [csha_pkg::SEL_W-1:0]      bin_index,
  output logic [csha_pkg::OUT_CNT_W-1:0]  bin_value,
  output logic [csha_pkg::STATUS_W-1:0]   status
);
  import csha_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * MAX_BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [BINS_W-1:0] NB_CAP =
    BINS_W'((MAX_BINS > (1 << BINS_W) - 1) ? (1 << BINS_W) - 1 : MAX_BINS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_UPDATE, S_DIVIDE, S_FETCH, S_BUMP, S_FINISH
  } state_t;

  // config registers
  logic                       hist_enable;
  logic signed [SAMPLE_W-1:0] hist_low;
  logic signed [HIGH_W-1:0]   hist_high;
  logic [BINS_W-1:0]          bins_in_use;
  logic                       cfg_wr;
  reg_idx_t                   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_enable <= 1'b0;
      hist_low    <= '0;
      hist_high   <= HIST_HIGH_RST;
      bins_in_use <= BINS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HIST_ENABLE: hist_enable <= pwdata[0];
        REG_HIST_LOW:    hist_low    <= pwdata[SAMPLE_W-1:0];
        REG_HIST_HIGH:   hist_high   <= pwdata[HIGH_W-1:0];
        REG_BINS_IN_USE: bins_in_use <= pwdata[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HIST_ENABLE: prdata = PDATA_W'(hist_enable);
      REG_HIST_LOW:    prdata = PDATA_W'(signed'(hist_low));
      REG_HIST_HIGH:   prdata = PDATA_W'(signed'(hist_high));
      REG_BINS_IN_USE: prdata = PDATA_W'(bins_in_use);
      default:         prdata = '0;
    endcase
  end

  // per-channel counters
  logic [COUNT_BITS-1:0]      finite_counts  [CHANNELS];
  logic [COUNT_BITS-1:0]      nan_counts     [CHANNELS];
  logic [COUNT_BITS-1:0]      pos_inf_counts [CHANNELS];
  logic [COUNT_BITS-1:0]      neg_inf_counts [CHANNELS];
  logic [COUNT_BITS-1:0]      below_counts   [CHANNELS];
  logic [COUNT_BITS-1:0]      above_counts   [CHANNELS];
  logic signed [SAMPLE_W-1:0] min_values     [CHANNELS];
  logic signed [SAMPLE_W-1:0] max_values     [CHANNELS];
  logic [CHANNELS-1:0]        seen_finite;

  // item registers
  state_t                     state;
  mode_t                      it_mode;
  logic [CH_W-1:0]            ch_idx;
  logic                       ch_ok;
  logic signed [SAMPLE_W-1:0] it_sample;
  class_t                     it_class;
  logic [BINS_W-1:0]          bin_q;
  logic [COUNT_BITS-1:0]      bval;
  logic                       touched;
  logic                       sat;
  logic                       clr_reply;
  logic [ADDR_W-1:0]          clr_addr;

  function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  // bin arithmetic
  logic                       in_accept;
  logic                       port_ch_ok;
  logic                       read_hit;
  logic                       below;
  logic                       above;
  logic                       need_bin;
  logic [SAMPLE_W+1:0]        diff;
  logic [SAMPLE_W+1:0]        span;
  logic [BINS_W-1:0]          nb0;
  logic [BINS_W-1:0]          nb_eff;
  logic [NUM_W-1:0]           numer;
  logic                       div_start;
  logic                       div_done;
  logic [NUM_W-1:0]           quot;
  logic [BINS_W-1:0]          bin_clamped;
  logic [ADDR_W-1:0]          bin_addr;
  logic                       mem_wr;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [COUNT_BITS-1:0]      mem_wdata;
  logic [COUNT_BITS-1:0]      mem_rdata;
  logic [COUNT_BITS-1:0]      bumped;

  assign in_ready   = (state == S_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign port_ch_ok = int'(channel) < CHANNELS;
  assign read_hit   = (mode_t'(mode) == MODE_READ) && port_ch_ok
                    && (int'(bin_select) < MAX_BINS);

  always_comb begin
    below  = $signed({it_sample[SAMPLE_W-1], it_sample})
           < $signed({hist_low[SAMPLE_W-1], hist_low});
    above  = $signed({it_sample[SAMPLE_W-1], it_sample}) >= $signed(hist_high);
    diff   = {{2{it_sample[SAMPLE_W-1]}}, it_sample} - {{2{hist_low[SAMPLE_W-1]}}, hist_low};
    span   = {hist_high[HIGH_W-1], hist_high} - {{2{hist_low[SAMPLE_W-1]}}, hist_low};
    nb0    = (bins_in_use == '0) ? BINS_W'(1) : bins_in_use;
    nb_eff = (nb0 > NB_CAP) ? NB_CAP : nb0;
    numer  = NUM_W'(diff[DIFF_W-1:0]) * NUM_W'(nb_eff);
    need_bin  = (it_class == CLS_FINITE) && hist_enable && !below && !above;
    div_start = (state == S_UPDATE) && need_bin;
    bin_clamped = (quot >= NUM_W'(nb_eff)) ? nb_eff - BINS_W'(1) : quot[BINS_W-1:0];
    bin_addr  = ADDR_W'(ch_idx) * ADDR_W'(MAX_BINS) + ADDR_W'(bin_q);
    bumped    = inc_sat(mem_rdata);
    mem_wr    = (state == S_CLEAR) || ((state == S_BUMP) && (it_mode == MODE_OBSERVE));
    mem_waddr = (state == S_CLEAR) ? clr_addr : bin_addr;
    mem_wdata = (state == S_CLEAR) ? '0 : bumped;
  end

  csha_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (span[SPAN_W-1:0]),
    .done  (div_done),
    .quot  (quot)
  );

  csha_bin_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_BITS),
    .DEPTH  (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (bin_addr),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      clr_reply   <= 1'b0;
      out_valid   <= 1'b0;
      seen_finite <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        finite_counts[i]  <= '0;
        nan_counts[i]     <= '0;
        pos_inf_counts[i] <= '0;
        neg_inf_counts[i] <= '0;
        below_counts[i]   <= '0;
        above_counts[i]   <= '0;
        min_values[i]     <= '0;
        max_values[i]     <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= clr_reply ? S_FINISH : S_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            it_mode   <= mode_t'(mode);
            ch_idx    <= CH_W'(channel);
            ch_ok     <= port_ch_ok;
            it_sample <= sample;
            it_class  <= class_t'(sample_class);
            bin_q     <= (mode_t'(mode) == MODE_READ) ? BINS_W'(bin_select) : '0;
            bval      <= '0;
            touched   <= read_hit;
            sat       <= 1'b0;
            case (mode_t'(mode))
              MODE_CLEAR: begin
                seen_finite <= '0;
                for (int i = 0; i < CHANNELS; i++) begin
                  finite_counts[i]  <= '0;
                  nan_counts[i]     <= '0;
                  pos_inf_counts[i] <= '0;
                  neg_inf_counts[i] <= '0;
                  below_counts[i]   <= '0;
                  above_counts[i]   <= '0;
                  min_values[i]     <= '0;
                  max_values[i]     <= '0;
                end
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              MODE_OBSERVE: state <= port_ch_ok ? S_UPDATE : S_FINISH;
              MODE_READ: state <= read_hit ? S_FETCH : S_FINISH;
              default: state <= S_FINISH;
            endcase
          end
        end
        S_UPDATE: begin
          state <= need_bin ? S_DIVIDE : S_FINISH;
          case (it_class)
            CLS_NAN: begin
              sat <= &nan_counts[ch_idx];
              nan_counts[ch_idx] <= inc_sat(nan_counts[ch_idx]);
            end
            CLS_POS_INF: begin
              sat <= &pos_inf_counts[ch_idx];
              pos_inf_counts[ch_idx] <= inc_sat(pos_inf_counts[ch_idx]);
            end
            CLS_NEG_INF: begin
              sat <= &neg_inf_counts[ch_idx];
              neg_inf_counts[ch_idx] <= inc_sat(neg_inf_counts[ch_idx]);
            end
            default: begin
              finite_counts[ch_idx] <= inc_sat(finite_counts[ch_idx]);
              seen_finite[ch_idx]   <= 1'b1;
              if (!seen_finite[ch_idx] || it_sample < min_values[ch_idx]) begin
                min_values[ch_idx] <= it_sample;
              end
              if (!seen_finite[ch_idx] || it_sample > max_values[ch_idx]) begin
                max_values[ch_idx] <= it_sample;
              end
              if (hist_enable && below) begin
                sat <= (&finite_counts[ch_idx]) || (&below_counts[ch_idx]);
                below_counts[ch_idx] <= inc_sat(below_counts[ch_idx]);
              end else if (hist_enable && above) begin
                sat <= (&finite_counts[ch_idx]) || (&above_counts[ch_idx]);
                above_counts[ch_idx] <= inc_sat(above_counts[ch_idx]);
              end else begin
                sat <= &finite_counts[ch_idx];
              end
            end
          endcase
        end
        S_DIVIDE: begin
          if (div_done) begin
            bin_q   <= bin_clamped;
            touched <= 1'b1;
            state   <= S_FETCH;
          end
        end
        S_FETCH: state <= S_BUMP;
        S_BUMP: begin
          if (it_mode == MODE_OBSERVE) begin
            bval <= bumped;
            sat  <= sat || (&mem_rdata);
          end else begin
            bval <= mem_rdata;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
            if (ch_ok && it_mode != MODE_CLEAR) begin
              finite_total  <= OUT_CNT_W'(finite_counts[ch_idx]);
              nan_total     <= OUT_CNT_W'(nan_counts[ch_idx]);
              pos_inf_total <= OUT_CNT_W'(pos_inf_counts[ch_idx]);
              neg_inf_total <= OUT_CNT_W'(neg_inf_counts[ch_idx]);
              below_total   <= OUT_CNT_W'(below_counts[ch_idx]);
              above_total   <= OUT_CNT_W'(above_counts[ch_idx]);
              min_seen      <= min_values[ch_idx];
              max_seen      <= max_values[ch_idx];
              has_finite    <= seen_finite[ch_idx];
            end else begin
              finite_total  <= '0;
              nan_total     <= '0;
              pos_inf_total <= '0;
              neg_inf_total <= '0;
              below_total   <= '0;
              above_total   <= '0;
              min_seen      <= '0;
              max_seen      <= '0;
              has_finite    <= 1'b0;
            end
            if (ch_ok && (it_mode == MODE_OBSERVE || it_mode == MODE_READ)) begin
              bin_index <= bin_q[SEL_W-1:0];
              bin_value <= OUT_CNT_W'(bval);
              status    <= sat ? STAT_SAT : (touched ? STAT_BIN : STAT_NONE);
            end else begin
              bin_index <= '0;
              bin_value <= '0;
              status    <= STAT_NONE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/csha_checker.sv
// Port-level checks for the channel statistics histogram block, bound to the top.
// Depends on csha_pkg for widths and status codes.
module csha_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [csha_pkg::OUT_CNT_W-1:0] bin_value,
  input logic [csha_pkg::SAMPLE_W-1:0]  min_seen,
  input logic [csha_pkg::SAMPLE_W-1:0]  max_seen,
  input logic                           has_finite,
  input logic [csha_pkg::STATUS_W-1:0]  status
);
  import csha_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin_value) && $stable(status))
    else $error("result beat changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while item in flight");

  a_no_bin: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_NONE |-> bin_value == '0)
    else $error("bin value without touched bin");

  a_minmax: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_finite |-> min_seen == '0 && max_seen == '0)
    else $error("min or max set before any finite sample");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("handshake active after reset");

endmodule

bind channel_stats_histogram_accumulator_core csha_checker u_csha_checker (.*);
